[rtl/core/uvst_pkg.sv]
// Shared constants, codes and types for the unique value set table.
package uvst_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ELEMENT_W   = 32;
    localparam int COUNT_W     = 5;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ERASE  = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef struct packed {
        logic insert;
        logic erase;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic occ;
        logic shift;
    } link_t;

endpackage

[rtl/core/uvst_cell.sv]
// One storage cell of the set: holds a value and its occupied flag.
module uvst_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  uvst_pkg::cmd_t                 cmd,
    input  logic [uvst_pkg::VALUE_WIDTH-1:0] value,
    input  uvst_pkg::link_t                link_in,
    input  logic                           up_occ,
    input  logic [uvst_pkg::VALUE_WIDTH-1:0] up_val,
    output uvst_pkg::link_t                link_out,
    output logic [uvst_pkg::VALUE_WIDTH-1:0] val
);

    logic                             occ_reg;
    logic                             occ_next;
    logic [uvst_pkg::VALUE_WIDTH-1:0] val_reg;
    logic [uvst_pkg::VALUE_WIDTH-1:0] val_next;
    logic                             hit;
    logic                             shift_here;
    logic                             slot_free;

    assign hit        = occ_reg && (val_reg == value);
    assign shift_here = hit || link_in.shift;
    assign slot_free  = !occ_reg && link_in.occ;

    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        if (cmd.clear)
        begin
            occ_next = 1'b0;
        end
        else if (cmd.erase && shift_here)
        begin
            // close the gap: take the neighbour above
            occ_next = up_occ;
            val_next = up_val;
        end
        else if (cmd.insert && slot_free)
        begin
            occ_next = 1'b1;
            val_next = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link_out.occ   = occ_reg;
    assign link_out.shift = shift_here;
    assign val            = val_reg;

endmodule

[rtl/core/unique_value_set_table.sv]
// Top level of the unique value set table: a row of storage cells and the count.
// An accepted request's result is written to the output register in the cycle after it is taken.
// Throughput: one request per cycle while the output side is not stalled.
// All compares and the erase compaction happen in the cell row, in the cycle in which the request is accepted.
// Reset clears the count, every occupied flag and the output valid; stored values
// are left as they are and are never read before being written.
module unique_value_set_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [uvst_pkg::ELEMENT_W-1:0] element,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [uvst_pkg::COUNT_W-1:0]   count,
    output logic                           is_empty
);

    localparam int D = uvst_pkg::DEPTH;

    logic                             accept;
    logic [uvst_pkg::VALUE_WIDTH-1:0] value;
    uvst_pkg::cmd_t                   cmd;
    uvst_pkg::link_t                  link [D:0];
    logic [uvst_pkg::VALUE_WIDTH-1:0] vals [D:0];
    logic [D-1:0]                     occ_above;
    logic                             found;
    logic                             full;
    logic                             none;

    logic [uvst_pkg::CNT_W-1:0]       cnt_reg;
    logic [uvst_pkg::CNT_W-1:0]       cnt_next;
    uvst_pkg::status_t                st_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    uvst_pkg::status_t                status_reg;
    logic [uvst_pkg::COUNT_W-1:0]     count_reg;
    logic                             empty_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign value    = uvst_pkg::VALUE_WIDTH'(element);

    assign link[0].occ   = 1'b1;
    assign link[0].shift = 1'b0;
    assign vals[D]       = '0;

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            // occupied flag of the cell above; nothing above the top cell
            if (g + 1 < D)
            begin : g_mid
                assign occ_above[g] = link[g + 2].occ;
            end
            else
            begin : g_top
                assign occ_above[g] = 1'b0;
            end

            uvst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .value    (value),
                .link_in  (link[g]),
                .up_occ   (occ_above[g]),
                .up_val   (vals[g + 1]),
                .link_out (link[g + 1]),
                .val      (vals[g])
            );
        end
    endgenerate

    // link[g+1] carries cell g; the topmost shift flag tells whether any cell matched
    assign found = link[D].shift;
    assign full  = (cnt_reg == uvst_pkg::CNT_W'(D));
    assign none  = (cnt_reg == '0);

    always_comb
    begin
        cmd      = '0;
        cnt_next = cnt_reg;
        st_next  = uvst_pkg::ST_OK;
        if (accept)
        begin
            unique case (func)
                uvst_pkg::FUNC_INSERT:
                begin
                    if (full)
                    begin
                        st_next = uvst_pkg::ST_FULL;
                    end
                    else if (found)
                    begin
                        st_next = uvst_pkg::ST_DUP;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
                uvst_pkg::FUNC_ERASE:
                begin
                    if (none)
                    begin
                        st_next = uvst_pkg::ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        st_next = uvst_pkg::ST_MISSING;
                    end
                    else
                    begin
                        cmd.erase = 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                end
                uvst_pkg::FUNC_CLEAR:
                begin
                    cmd.clear = 1'b1;
                    cnt_next  = '0;
                end
                default:
                begin
                    st_next = uvst_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= st_next;
            count_reg  <= uvst_pkg::COUNT_W'(cnt_next);
            empty_reg  <= (cnt_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign is_empty  = empty_reg;

`ifndef SYNTHESIS
    logic [D-1:0] occ_vec;
    logic [D-1:0] occ_expect;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            occ_vec[i]    = link[i + 1].occ;
            occ_expect[i] = (uvst_pkg::CNT_W'(i) < cnt_reg);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= uvst_pkg::CNT_W'(D))
        else $error("count beyond depth");

    a_occ_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        occ_vec == occ_expect)
        else $error("occupied cells do not match count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not grow count");

    a_erase_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.erase |-> found && !none)
        else $error("erase without a match");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> empty_reg == (count_reg == '0))
        else $error("empty flag disagrees with count");
`endif

endmodule
